>>> rtl/core/assert_macros.svh
// Assertion macros for the dq sliding-mode current controller.
// Checks compile in simulation and vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DQ_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

`define DQ_ASSERT_NEVER(lbl, ck, rn, expr, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error(msg);

`else

`define DQ_ASSERT(lbl, ck, rn, prop, msg)

`define DQ_ASSERT_NEVER(lbl, ck, rn, expr, msg)

`endif

`endif

>>> rtl/core/dqsmc_pkg.sv
// Shared types and constants of the dq sliding-mode current controller.
// No dependencies.
`default_nettype none

package dqsmc_pkg;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t CFG_SURFACE_SLOPE = 3'd0;
    localparam cfg_idx_t CFG_SWITCH_GAIN   = 3'd1;
    localparam cfg_idx_t CFG_INV_BOUNDARY  = 3'd2;
    localparam cfg_idx_t CFG_DRIVE_MIN     = 3'd3;
    localparam cfg_idx_t CFG_DRIVE_MAX     = 3'd4;
    localparam cfg_idx_t CFG_DT_STEP       = 3'd5;

    localparam logic [30:0] RST_SURFACE_SLOPE = 31'd32768000;
    localparam logic [31:0] RST_SWITCH_GAIN   = 32'd1572864;
    localparam logic [30:0] RST_INV_BOUNDARY  = 31'd13107;
    localparam logic [31:0] RST_DRIVE_MIN     = 32'hFFE8_0000;
    localparam logic [31:0] RST_DRIVE_MAX     = 32'd1572864;
    localparam logic [31:0] RST_DT_STEP       = 32'd429497;

    typedef logic [1:0] clr_sel_t;

    localparam clr_sel_t CLR_D    = 2'd0;
    localparam clr_sel_t CLR_Q    = 2'd1;
    localparam clr_sel_t CLR_BOTH = 2'd2;

    // +1.0 and -1.0 in Q2.16, 18 bits signed
    localparam logic signed [17:0] UNIT_POS = 18'sd65536;
    localparam logic signed [17:0] UNIT_NEG = -18'sd65536;

    typedef struct packed {
        logic [30:0] surface_slope;
        logic [31:0] switch_gain;
        logic [30:0] inv_boundary;
        logic [31:0] drive_min;
        logic [31:0] drive_max;
        logic [31:0] dt_step;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ERR,
        OP_MUL_INC,
        OP_INTEG,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_SUM,
        OP_SURF,
        OP_MUL_SURF,
        OP_UNIT,
        OP_MUL_GAIN,
        OP_CLAMP
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MINC,
        S_INTG,
        S_MHI,
        S_MLO,
        S_SUM,
        S_SURF,
        S_MSURF,
        S_UNIT,
        S_MGAIN,
        S_CLAMP,
        S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   axis;   // 0 d, 1 q
        logic   load;   // capture input word, apply clear
        logic   push;   // move finished result to output register
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/core/dqsmc_datapath.sv
// Datapath of the dq sliding-mode current controller: shared 33x33 multiplier,
// per-axis integrals, result staging and output register. Uses dqsmc_pkg.
`default_nettype none

module dqsmc_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dqsmc_pkg::cmd_t    cmd,
    output dqsmc_pkg::status_t      status,
    input  wire dqsmc_pkg::cfg_t    cfg,
    input  wire logic [2:0]         s_tuser,
    input  wire logic [127:0]       s_tdata,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic [135:0]            m_tdata
);

    logic [127:0]        in_data_reg;
    logic signed [31:0]  err_reg;
    logic signed [65:0]  prod_reg;
    logic signed [47:0]  now_reg;
    logic signed [55:0]  hi_prod_reg;
    logic signed [47:0]  term_reg;
    logic signed [31:0]  surf_reg;
    logic signed [17:0]  unit_reg;
    logic signed [47:0]  integ_d_reg;
    logic signed [47:0]  integ_q_reg;
    logic [31:0]         res_vd_reg;
    logic [31:0]         res_vq_reg;
    logic [31:0]         res_sd_reg;
    logic [31:0]         res_sq_reg;
    logic                res_cd_reg;
    logic                res_cq_reg;
    logic [129:0]        out_data_reg;
    logic                out_valid_reg;

    logic [31:0]         ref_sel;
    logic [31:0]         meas_sel;
    logic signed [32:0]  diff;
    logic signed [31:0]  err_next;
    logic signed [47:0]  integ_old;
    logic signed [50:0]  integ_sum;
    logic signed [47:0]  now_next;
    logic [79:0]         wide_sum;
    logic signed [48:0]  surf_sum;
    logic signed [31:0]  surf_next;
    logic signed [49:0]  unit_q;
    logic signed [17:0]  unit_next;
    logic signed [32:0]  raw;
    logic signed [32:0]  lim_max;
    logic signed [32:0]  lim_min;
    logic                over_max;
    logic                under_min;
    logic                clamp_hit;
    logic [31:0]         v_next;
    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic signed [65:0]  mul_p;

    assign ref_sel  = cmd.axis ? in_data_reg[95:64]  : in_data_reg[31:0];
    assign meas_sel = cmd.axis ? in_data_reg[127:96] : in_data_reg[63:32];
    assign diff     = $signed({ref_sel[31], ref_sel}) - $signed({meas_sel[31], meas_sel});

    always_comb
    begin
        if (diff[32] != diff[31])
            err_next = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            err_next = diff[31:0];
    end

    // integral + floor(err * dt / 2^16), saturated to 48 bits
    assign integ_old = cmd.axis ? integ_q_reg : integ_d_reg;
    assign integ_sum = $signed({{3{integ_old[47]}}, integ_old})
                     + $signed({prod_reg[65], prod_reg[65:16]});

    always_comb
    begin
        if (integ_sum[50:47] == {4{integ_sum[47]}})
            now_next = integ_sum[47:0];
        else
            now_next = integ_sum[50] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end

    // slope * integral = (slope * hi) << 24 + slope * lo, then >> 32
    assign wide_sum = {hi_prod_reg, 24'd0} + {24'd0, prod_reg[55:0]};

    assign surf_sum = $signed({{17{err_reg[31]}}, err_reg})
                    + $signed({term_reg[47], term_reg});

    always_comb
    begin
        if (surf_sum[48:31] == {18{surf_sum[31]}})
            surf_next = surf_sum[31:0];
        else
            surf_next = surf_sum[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    assign unit_q = prod_reg[65:16];

    always_comb
    begin
        if (unit_q > 50'sd65536)
            unit_next = dqsmc_pkg::UNIT_POS;
        else if (unit_q < -50'sd65536)
            unit_next = dqsmc_pkg::UNIT_NEG;
        else
            unit_next = unit_q[17:0];
    end

    // gain * unit fits 49 bits, so the drive fits 33 bits
    assign raw       = prod_reg[48:16];
    assign lim_max   = $signed({cfg.drive_max[31], cfg.drive_max});
    assign lim_min   = $signed({cfg.drive_min[31], cfg.drive_min});
    assign over_max  = raw > lim_max;
    assign under_min = raw < lim_min;
    assign clamp_hit = over_max || under_min;

    always_comb
    begin
        if (over_max)
            v_next = cfg.drive_max;
        else if (under_min)
            v_next = cfg.drive_min;
        else
            v_next = raw[31:0];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            dqsmc_pkg::OP_MUL_INC:
            begin
                mul_a = {err_reg[31], err_reg};
                mul_b = {1'b0, cfg.dt_step};
            end
            dqsmc_pkg::OP_MUL_HI:
            begin
                mul_a = {2'b00, cfg.surface_slope};
                mul_b = {{9{now_reg[47]}}, now_reg[47:24]};
            end
            dqsmc_pkg::OP_MUL_LO:
            begin
                mul_a = {2'b00, cfg.surface_slope};
                mul_b = {9'd0, now_reg[23:0]};
            end
            dqsmc_pkg::OP_MUL_SURF:
            begin
                mul_a = {surf_reg[31], surf_reg};
                mul_b = {2'b00, cfg.inv_boundary};
            end
            dqsmc_pkg::OP_MUL_GAIN:
            begin
                mul_a = {cfg.switch_gain[31], cfg.switch_gain};
                mul_b = {{15{unit_reg[17]}}, unit_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_data_reg <= s_tdata;
        if (cmd.push)
            out_data_reg <= {res_cq_reg, res_cd_reg, res_sq_reg, res_sd_reg,
                             res_vq_reg, res_vd_reg};
        case (cmd.op)
            dqsmc_pkg::OP_ERR:      err_reg <= err_next;
            dqsmc_pkg::OP_MUL_INC:  prod_reg <= mul_p;
            dqsmc_pkg::OP_INTEG:    now_reg <= now_next;
            dqsmc_pkg::OP_MUL_HI:   prod_reg <= mul_p;
            dqsmc_pkg::OP_MUL_LO:
            begin
                hi_prod_reg <= prod_reg[55:0];
                prod_reg    <= mul_p;
            end
            dqsmc_pkg::OP_SUM:      term_reg <= wide_sum[79:32];
            dqsmc_pkg::OP_SURF:     surf_reg <= surf_next;
            dqsmc_pkg::OP_MUL_SURF: prod_reg <= mul_p;
            dqsmc_pkg::OP_UNIT:     unit_reg <= unit_next;
            dqsmc_pkg::OP_MUL_GAIN: prod_reg <= mul_p;
            dqsmc_pkg::OP_CLAMP:
            begin
                if (cmd.axis)
                begin
                    res_vq_reg <= v_next;
                    res_sq_reg <= surf_reg;
                    res_cq_reg <= clamp_hit;
                end
                else
                begin
                    res_vd_reg <= v_next;
                    res_sd_reg <= surf_reg;
                    res_cd_reg <= clamp_hit;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_d_reg   <= '0;
            integ_q_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && s_tuser[0])
            begin
                case (s_tuser[2:1])
                    dqsmc_pkg::CLR_D:    integ_d_reg <= '0;
                    dqsmc_pkg::CLR_Q:    integ_q_reg <= '0;
                    dqsmc_pkg::CLR_BOTH:
                    begin
                        integ_d_reg <= '0;
                        integ_q_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.op == dqsmc_pkg::OP_CLAMP && !clamp_hit)
            begin
                if (cmd.axis)
                    integ_q_reg <= now_reg;
                else
                    integ_d_reg <= now_reg;
            end

            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.out_full = out_valid_reg;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {6'd0, out_data_reg};

endmodule

`default_nettype wire

>>> rtl/core/dqsmc_ctrl.sv
// Sequencer of the dq sliding-mode current controller: steps the datapath through
// both axes and hands results to the output register. Uses dqsmc_pkg, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dqsmc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               is_clear,
    input  wire logic               m_tready,
    input  wire dqsmc_pkg::status_t status,
    output dqsmc_pkg::cmd_t         cmd
);

    dqsmc_pkg::state_t state_reg;
    dqsmc_pkg::state_t state_next;
    logic              axis_reg;
    logic              axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dqsmc_pkg::S_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        s_tready   = 1'b0;
        cmd.op     = dqsmc_pkg::OP_NONE;
        cmd.axis   = axis_reg;
        cmd.load   = 1'b0;
        cmd.push   = 1'b0;
        unique case (state_reg)
            dqsmc_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid && !is_clear)
                begin
                    axis_next  = 1'b0;
                    state_next = dqsmc_pkg::S_ERR;
                end
            end
            dqsmc_pkg::S_ERR:
            begin
                cmd.op     = dqsmc_pkg::OP_ERR;
                state_next = dqsmc_pkg::S_MINC;
            end
            dqsmc_pkg::S_MINC:
            begin
                cmd.op     = dqsmc_pkg::OP_MUL_INC;
                state_next = dqsmc_pkg::S_INTG;
            end
            dqsmc_pkg::S_INTG:
            begin
                cmd.op     = dqsmc_pkg::OP_INTEG;
                state_next = dqsmc_pkg::S_MHI;
            end
            dqsmc_pkg::S_MHI:
            begin
                cmd.op     = dqsmc_pkg::OP_MUL_HI;
                state_next = dqsmc_pkg::S_MLO;
            end
            dqsmc_pkg::S_MLO:
            begin
                cmd.op     = dqsmc_pkg::OP_MUL_LO;
                state_next = dqsmc_pkg::S_SUM;
            end
            dqsmc_pkg::S_SUM:
            begin
                cmd.op     = dqsmc_pkg::OP_SUM;
                state_next = dqsmc_pkg::S_SURF;
            end
            dqsmc_pkg::S_SURF:
            begin
                cmd.op     = dqsmc_pkg::OP_SURF;
                state_next = dqsmc_pkg::S_MSURF;
            end
            dqsmc_pkg::S_MSURF:
            begin
                cmd.op     = dqsmc_pkg::OP_MUL_SURF;
                state_next = dqsmc_pkg::S_UNIT;
            end
            dqsmc_pkg::S_UNIT:
            begin
                cmd.op     = dqsmc_pkg::OP_UNIT;
                state_next = dqsmc_pkg::S_MGAIN;
            end
            dqsmc_pkg::S_MGAIN:
            begin
                cmd.op     = dqsmc_pkg::OP_MUL_GAIN;
                state_next = dqsmc_pkg::S_CLAMP;
            end
            dqsmc_pkg::S_CLAMP:
            begin
                cmd.op = dqsmc_pkg::OP_CLAMP;
                if (axis_reg)
                    state_next = dqsmc_pkg::S_DONE;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = dqsmc_pkg::S_ERR;
                end
            end
            dqsmc_pkg::S_DONE:
            begin
                if (!status.out_full || m_tready)
                begin
                    cmd.push   = 1'b1;
                    state_next = dqsmc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dqsmc_pkg::S_IDLE;
            end
        endcase
    end

    `DQ_ASSERT(a_start_compute, clk, rst_n, (s_tvalid && s_tready && !is_clear) |=> (state_reg == dqsmc_pkg::S_ERR && !axis_reg), "compute word did not start d axis")
    `DQ_ASSERT_NEVER(a_ready_busy, clk, rst_n, (state_reg != dqsmc_pkg::S_IDLE) && s_tready, "ready while busy")
    `DQ_ASSERT(a_push_room, clk, rst_n, cmd.push |-> (!status.out_full || m_tready), "result pushed over pending word")
    `DQ_ASSERT(a_axis_order, clk, rst_n, (state_reg == dqsmc_pkg::S_CLAMP && !axis_reg) |=> (state_reg == dqsmc_pkg::S_ERR && axis_reg), "q axis did not follow d axis")

endmodule

`default_nettype wire

>>> rtl/core/dq_sliding_mode_current_controller.sv
// Top level of the dq sliding-mode current controller: tuning registers,
// sequencer and datapath. Uses dqsmc_pkg, dqsmc_ctrl, dqsmc_datapath.
//
// Channel  Dir  Fields
// s_*      in   tdata: ref_d, meas_d, ref_q, meas_q; tuser: command, clear_select
// m_*      out  tdata: v_d, v_q, surface_d, surface_q, clamped_d, clamped_q
// cfg_*    in   write only: surface_slope .. dt_step at index 0 .. 5
//
// A compute word holds the sequencer from acceptance through 11 steps per axis, run in
// turn on one shared 33x33 multiplier (five products per axis), to a hand-off state that
// pushes its result into the output register.
// A clear word is taken in the idle state, leaves the sequencer idle and gives no result.
// Reset restores the tuning defaults and zeroes both integrals.
// A waiting result does not block acceptance; a finished result waits for the
// output register to free up, and input waits with it.
`default_nettype none

module dq_sliding_mode_current_controller (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // ref_d, meas_d, ref_q, meas_q
    input  wire logic [2:0]   s_tuser,  // command, clear_select
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,  // v_d, v_q, surface_d, surface_q, clamped_d, clamped_q
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    dqsmc_pkg::cfg_t    cfg_reg;
    dqsmc_pkg::cmd_t    cmd;
    dqsmc_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.surface_slope <= dqsmc_pkg::RST_SURFACE_SLOPE;
            cfg_reg.switch_gain   <= dqsmc_pkg::RST_SWITCH_GAIN;
            cfg_reg.inv_boundary  <= dqsmc_pkg::RST_INV_BOUNDARY;
            cfg_reg.drive_min     <= dqsmc_pkg::RST_DRIVE_MIN;
            cfg_reg.drive_max     <= dqsmc_pkg::RST_DRIVE_MAX;
            cfg_reg.dt_step       <= dqsmc_pkg::RST_DT_STEP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dqsmc_pkg::CFG_SURFACE_SLOPE: cfg_reg.surface_slope <= cfg_data[30:0];
                dqsmc_pkg::CFG_SWITCH_GAIN:   cfg_reg.switch_gain   <= cfg_data;
                dqsmc_pkg::CFG_INV_BOUNDARY:  cfg_reg.inv_boundary  <= cfg_data[30:0];
                dqsmc_pkg::CFG_DRIVE_MIN:     cfg_reg.drive_min     <= cfg_data;
                dqsmc_pkg::CFG_DRIVE_MAX:     cfg_reg.drive_max     <= cfg_data;
                dqsmc_pkg::CFG_DT_STEP:       cfg_reg.dt_step       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    dqsmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .is_clear (s_tuser[0]),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dqsmc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .cfg      (cfg_reg),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> test/dq_sliding_mode_current_controller_tb.sv
// Self-checking testbench for dq_sliding_mode_current_controller: directed and random
// words on the input stream, tuning rewritten between phases, results checked in order.
// Depends on dqsmc_pkg and the controller RTL only.
module dq_sliding_mode_current_controller_tb;

    typedef logic signed [127:0] wide_t;

    localparam logic                CMD_COMPUTE = 1'b0;
    localparam logic                CMD_CLEAR   = 1'b1;
    localparam dqsmc_pkg::clr_sel_t CLR_NONE    = 2'd3;

    localparam wide_t I32_MAX  = 128'sd2147483647;
    localparam wide_t I32_MIN  = -128'sd2147483648;
    localparam wide_t I48_MAX  = 128'sd140737488355327;
    localparam wide_t I48_MIN  = -128'sd140737488355328;
    localparam wide_t UNIT_ONE = 128'sd65536;

    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_WORDS = 105;
    localparam int SETTLE      = 40;

    typedef struct {
        logic                cmd;
        dqsmc_pkg::clr_sel_t sel;
        logic [31:0]         ref_d;
        logic [31:0]         meas_d;
        logic [31:0]         ref_q;
        logic [31:0]         meas_q;
    } word_t;

    typedef struct {
        logic [31:0] v_d;
        logic [31:0] v_q;
        logic [31:0] surf_d;
        logic [31:0] surf_q;
        logic        clamp_d;
        logic        clamp_q;
    } drive_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [127:0]        s_tdata;
    logic [2:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [135:0]        m_tdata;
    logic                cfg_we;
    dqsmc_pkg::cfg_idx_t cfg_index;
    logic [31:0]         cfg_data;

    dq_sliding_mode_current_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller state as the testbench sees it
    logic [30:0]        tune_slope;
    logic signed [31:0] tune_gain;
    logic [30:0]        tune_inv_phi;
    logic signed [31:0] tune_vmin;
    logic signed [31:0] tune_vmax;
    logic [31:0]        tune_dt;
    logic signed [47:0] integ_d;
    logic signed [47:0] integ_q;

    word_t  stim_words[$];
    drive_t pending_drives[$];
    word_t  next_word;

    logic in_taken;
    int   in_gap;
    int   out_gap;
    logic calm;
    int   cycles;
    int   errors;
    int   n_compute;
    int   n_clear;
    int   n_clamped;
    int   phase;
    int   k;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic wide_t clip(input wide_t x, input wide_t lo, input wide_t hi);
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    // one axis of the sliding-mode law; integral restored when the output clamp acts
    task automatic axis_step(input logic signed [31:0] r, input logic signed [31:0] m,
                             inout logic signed [47:0] integ,
                             output logic [31:0] v, output logic [31:0] s,
                             output logic c);
        wide_t rw, mw, e, old_i, now_i, sw, unit, raw, vw;
        wide_t slw, gw, ibw, dtw, lo, hi;
        rw    = r;
        mw    = m;
        slw   = tune_slope;
        gw    = tune_gain;
        ibw   = tune_inv_phi;
        dtw   = tune_dt;
        lo    = tune_vmin;
        hi    = tune_vmax;
        old_i = integ;
        e     = clip(rw - mw, I32_MIN, I32_MAX);
        now_i = clip(old_i + ((e * dtw) >>> 16), I48_MIN, I48_MAX);
        sw    = clip(e + ((slw * now_i) >>> 32), I32_MIN, I32_MAX);
        unit  = clip((sw * ibw) >>> 16, -UNIT_ONE, UNIT_ONE);
        raw   = (gw * unit) >>> 16;
        if (raw > hi)
            vw = hi;
        else if (raw < lo)
            vw = lo;
        else
            vw = raw;
        c     = (vw != raw);
        integ = c ? old_i[47:0] : now_i[47:0];
        v     = vw[31:0];
        s     = sw[31:0];
    endtask

    task automatic predict_drive(input logic [127:0] data, input logic [2:0] user);
        drive_t d;
        dqsmc_pkg::clr_sel_t sel;
        sel = user[2:1];
        if (user[0] == CMD_CLEAR)
        begin
            n_clear++;
            if (sel == dqsmc_pkg::CLR_D || sel == dqsmc_pkg::CLR_BOTH)
                integ_d = '0;
            if (sel == dqsmc_pkg::CLR_Q || sel == dqsmc_pkg::CLR_BOTH)
                integ_q = '0;
        end
        else
        begin
            n_compute++;
            axis_step(data[31:0], data[63:32], integ_d, d.v_d, d.surf_d, d.clamp_d);
            axis_step(data[95:64], data[127:96], integ_q, d.v_q, d.surf_q, d.clamp_q);
            pending_drives.push_back(d);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // input side: hold a word until taken, random gaps between words
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                in_taken = 1'b0;
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (stim_words.size() > 0)
                begin
                    next_word = stim_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_word.meas_q, next_word.ref_q,
                                 next_word.meas_d, next_word.ref_d};
                    s_tuser  <= {next_word.sel, next_word.cmd};
                    if (!calm && $urandom_range(0, 7) == 0)
                        in_gap = $urandom_range(1, 18);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (calm)
            begin
                m_tready <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    out_gap = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                in_taken = 1'b1;
                predict_drive(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_drives.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    check_field("v_d", pending_drives[0].v_d, m_tdata[31:0]);
                    check_field("v_q", pending_drives[0].v_q, m_tdata[63:32]);
                    check_field("surface_d", pending_drives[0].surf_d, m_tdata[95:64]);
                    check_field("surface_q", pending_drives[0].surf_q, m_tdata[127:96]);
                    check_field("clamped_d", 32'(pending_drives[0].clamp_d),
                                32'(m_tdata[128]));
                    check_field("clamped_q", 32'(pending_drives[0].clamp_q),
                                32'(m_tdata[129]));
                    if (m_tdata[128] || m_tdata[129])
                        n_clamped++;
                    void'(pending_drives.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycles, pending_drives.size());
            $display("dq_sliding_mode_current_controller_tb: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input dqsmc_pkg::cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            dqsmc_pkg::CFG_SURFACE_SLOPE: tune_slope   = val[30:0];
            dqsmc_pkg::CFG_SWITCH_GAIN:   tune_gain    = val;
            dqsmc_pkg::CFG_INV_BOUNDARY:  tune_inv_phi = val[30:0];
            dqsmc_pkg::CFG_DRIVE_MIN:     tune_vmin    = val;
            dqsmc_pkg::CFG_DRIVE_MAX:     tune_vmax    = val;
            dqsmc_pkg::CFG_DT_STEP:       tune_dt      = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (stim_words.size() > 0 || s_tvalid || pending_drives.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_word(input logic cmd, input dqsmc_pkg::clr_sel_t sel,
                             input logic [31:0] rd, input logic [31:0] md,
                             input logic [31:0] rq, input logic [31:0] mq);
        word_t w;
        w.cmd    = cmd;
        w.sel    = sel;
        w.ref_d  = rd;
        w.meas_d = md;
        w.ref_q  = rq;
        w.meas_q = mq;
        stim_words.push_back(w);
    endtask

    function automatic logic [31:0] small_current(input int span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    function automatic logic [31:0] edge_current();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    task automatic push_random_word();
        logic        cmd;
        logic [31:0] rd, md, rq, mq;
        int          mode;
        cmd  = ($urandom_range(0, 11) == 0) ? CMD_CLEAR : CMD_COMPUTE;
        mode = $urandom_range(0, 9);
        if (mode < 2)
        begin
            rd = $urandom;
            md = $urandom;
            rq = $urandom;
            mq = $urandom;
        end
        else if (mode < 3)
        begin
            rd = edge_current();
            md = edge_current();
            rq = edge_current();
            mq = edge_current();
        end
        else
        begin
            // tracking near the reference, so the integral moves without saturating
            rd = small_current(1 << 22);
            rq = small_current(1 << 22);
            md = rd + small_current(1 << (mode + 10));
            mq = rq + small_current(1 << (mode + 10));
        end
        push_word(cmd, dqsmc_pkg::clr_sel_t'($urandom_range(0, 3)), rd, md, rq, mq);
    endtask

    task automatic load_tuning(input int kind);
        logic [31:0] lo, hi;
        case (kind)
            0:
            begin
                write_reg(dqsmc_pkg::CFG_SURFACE_SLOPE, 32'h7FFF_FFFF);
                write_reg(dqsmc_pkg::CFG_SWITCH_GAIN,   32'h7FFF_FFFF);
                write_reg(dqsmc_pkg::CFG_INV_BOUNDARY,  32'h7FFF_FFFF);
                write_reg(dqsmc_pkg::CFG_DRIVE_MIN,     32'h8000_0000);
                write_reg(dqsmc_pkg::CFG_DRIVE_MAX,     32'h7FFF_FFFF);
                write_reg(dqsmc_pkg::CFG_DT_STEP,       32'hFFFF_FFFF);
            end
            1:
            begin
                // zero boundary reciprocal: drive is zero before the clamp
                write_reg(dqsmc_pkg::CFG_SURFACE_SLOPE, 32'h0);
                write_reg(dqsmc_pkg::CFG_SWITCH_GAIN,   32'h8000_0000);
                write_reg(dqsmc_pkg::CFG_INV_BOUNDARY,  32'h0);
                write_reg(dqsmc_pkg::CFG_DRIVE_MIN,     32'h0);
                write_reg(dqsmc_pkg::CFG_DRIVE_MAX,     32'h0);
                write_reg(dqsmc_pkg::CFG_DT_STEP,       32'h0);
            end
            2:
            begin
                // crossed limits
                write_reg(dqsmc_pkg::CFG_SURFACE_SLOPE, {1'b1, dqsmc_pkg::RST_SURFACE_SLOPE});
                write_reg(dqsmc_pkg::CFG_SWITCH_GAIN,   {$urandom} >> $urandom_range(0, 8));
                write_reg(dqsmc_pkg::CFG_INV_BOUNDARY,  32'($urandom_range(1, 1 << 20)));
                write_reg(dqsmc_pkg::CFG_DRIVE_MIN,     32'($urandom_range(0, 1 << 22)));
                write_reg(dqsmc_pkg::CFG_DRIVE_MAX,     -32'($urandom_range(0, 1 << 22)));
                write_reg(dqsmc_pkg::CFG_DT_STEP,       dqsmc_pkg::RST_DT_STEP);
            end
            3:
            begin
                // most negative gain with unit -1 gives +2^31, always clamped
                write_reg(dqsmc_pkg::CFG_SURFACE_SLOPE, 32'(dqsmc_pkg::RST_SURFACE_SLOPE));
                write_reg(dqsmc_pkg::CFG_SWITCH_GAIN,   32'h8000_0000);
                write_reg(dqsmc_pkg::CFG_INV_BOUNDARY,  32'h7FFF_FFFF);
                write_reg(dqsmc_pkg::CFG_DRIVE_MIN,     32'h8000_0000);
                write_reg(dqsmc_pkg::CFG_DRIVE_MAX,     32'h7FFF_FFFF);
                write_reg(dqsmc_pkg::CFG_DT_STEP,       32'($urandom_range(0, 1 << 24)));
            end
            4:
            begin
                write_reg(dqsmc_pkg::CFG_SURFACE_SLOPE, $urandom);
                write_reg(dqsmc_pkg::CFG_SWITCH_GAIN,   $urandom);
                write_reg(dqsmc_pkg::CFG_INV_BOUNDARY,  $urandom);
                write_reg(dqsmc_pkg::CFG_DRIVE_MIN,     $urandom);
                write_reg(dqsmc_pkg::CFG_DRIVE_MAX,     $urandom);
                write_reg(dqsmc_pkg::CFG_DT_STEP,       $urandom);
            end
            default:
            begin
                lo = -32'($urandom_range(0, 1 << 25));
                hi = 32'($urandom_range(0, 1 << 25));
                write_reg(dqsmc_pkg::CFG_SURFACE_SLOPE,
                          {1'($urandom), 31'($urandom_range(0, 1 << 27))});
                write_reg(dqsmc_pkg::CFG_SWITCH_GAIN,   small_current(1 << 26));
                write_reg(dqsmc_pkg::CFG_INV_BOUNDARY,
                          {1'($urandom), 31'($urandom_range(1, 1 << 20))});
                write_reg(dqsmc_pkg::CFG_DRIVE_MIN,     lo);
                write_reg(dqsmc_pkg::CFG_DRIVE_MAX,     hi);
                write_reg(dqsmc_pkg::CFG_DT_STEP,       32'($urandom_range(0, 1 << 23)));
            end
        endcase
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = dqsmc_pkg::CFG_SURFACE_SLOPE;
        cfg_data     = '0;
        in_taken     = 1'b0;
        in_gap       = 0;
        out_gap      = 0;
        calm         = 1'b0;
        cycles       = 0;
        errors       = 0;
        n_compute    = 0;
        n_clear      = 0;
        n_clamped    = 0;
        tune_slope   = dqsmc_pkg::RST_SURFACE_SLOPE;
        tune_gain    = dqsmc_pkg::RST_SWITCH_GAIN;
        tune_inv_phi = dqsmc_pkg::RST_INV_BOUNDARY;
        tune_vmin    = dqsmc_pkg::RST_DRIVE_MIN;
        tune_vmax    = dqsmc_pkg::RST_DRIVE_MAX;
        tune_dt      = dqsmc_pkg::RST_DT_STEP;
        integ_d      = '0;
        integ_q      = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words on reset tuning
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_D, 32'h0, 32'h0, 32'h0, 32'h0);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_D, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_D, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF);
        push_word(CMD_CLEAR, CLR_NONE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_Q, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0);
        push_word(CMD_CLEAR, dqsmc_pkg::CLR_D, 32'h0, 32'h0, 32'h0, 32'h0);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_BOTH, 32'h0001_0000, 32'h0,
                  32'hFFFF_0000, 32'h0);
        push_word(CMD_CLEAR, dqsmc_pkg::CLR_Q, 32'h0, 32'h0, 32'h0, 32'h0);
        push_word(CMD_COMPUTE, CLR_NONE, 32'h0000_8000, 32'h0, 32'h0, 32'h0000_8000);
        push_word(CMD_CLEAR, dqsmc_pkg::CLR_BOTH, 32'h0, 32'h0, 32'h0, 32'h0);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_D, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h8000_0000, 32'h8000_0000);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_D, 32'h8000_0000, 32'h0000_0001,
                  32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_D, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 32'h0);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_D, 32'h0005_0000, 32'h0003_0000,
                  32'h0002_0000, 32'h0006_0000);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_D, 32'h0050_0000, 32'h0, 32'h0, 32'h0050_0000);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_D, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'hAAAA_AAAA, 32'h5555_5555);
        push_word(CMD_CLEAR, dqsmc_pkg::CLR_BOTH, 32'h0, 32'h0, 32'h0, 32'h0);
        push_word(CMD_COMPUTE, dqsmc_pkg::CLR_D, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0);
        wait_idle();

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            load_tuning(phase < 5 ? phase : 5);
            calm = (phase % 4 == 3) || (phase == NUM_PHASES - 1);
            if (phase % 3 == 0)
                push_word(CMD_CLEAR, dqsmc_pkg::CLR_BOTH, 32'h0, 32'h0, 32'h0, 32'h0);
            for (k = 0; k < PHASE_WORDS; k++)
                push_random_word();
            wait_idle();
        end

        $display("covered %0d compute and %0d clear words over %0d tuning sets,",
                 n_compute, n_clear, NUM_PHASES + 1);
        $display("%0d results with an axis clamped, %0d mismatches", n_clamped, errors);
        if (errors == 0)
            $display("dq_sliding_mode_current_controller_tb: done, clean");
        else
            $display("dq_sliding_mode_current_controller_tb: done, errors");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/dqsmc_pkg.sv
rtl/core/dqsmc_datapath.sv
rtl/core/dqsmc_ctrl.sv
rtl/core/dq_sliding_mode_current_controller.sv
test/dq_sliding_mode_current_controller_tb.sv
